>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL of the sparse domain store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RSD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RSD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RSD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/rsd_pkg.sv
// Types and constants of the reversible sparse domain store.
package rsd_pkg;

   localparam int NUM_VARS    = 16;
   localparam int MAX_SPAN    = 64;
   localparam int TRAIL_DEPTH = 1024;

   localparam int VAR_W    = 4;
   localparam int OFF_W    = 6;
   localparam int ADDR_W   = VAR_W + OFF_W;
   localparam int SIZE_W   = 7;
   localparam int CNT_W    = 11;
   localparam int TRAIL_AW = 10;

   localparam logic [2:0] ACT_INIT     = 3'd0;
   localparam logic [2:0] ACT_REMOVE   = 3'd1;
   localparam logic [2:0] ACT_FIX      = 3'd2;
   localparam logic [2:0] ACT_CONTAINS = 3'd3;
   localparam logic [2:0] ACT_READ     = 3'd4;
   localparam logic [2:0] ACT_MARK     = 3'd5;
   localparam logic [2:0] ACT_RESTORE  = 3'd6;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_RANGE = 2'd1;
   localparam logic [1:0] ERR_TRAIL = 2'd2;
   localparam logic [1:0] ERR_ARG   = 2'd3;

   localparam logic [1:0] KIND_DENSE = 2'd0;
   localparam logic [1:0] KIND_POS   = 2'd1;
   localparam logic [1:0] KIND_SIZE  = 2'd2;

   typedef struct packed {
      logic [2:0]        action;
      logic [VAR_W-1:0]  variable;
      logic signed [31:0] value;
      logic signed [31:0] value_high;
      logic [5:0]        slot;
      logic [CNT_W-1:0]  mark;
   } req_type;

   typedef struct packed {
      logic               present;
      logic               failed;
      logic [SIZE_W-1:0]  domain_size;
      logic signed [31:0] read_value;
      logic [CNT_W-1:0]   trail_length;
      logic [1:0]         error;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [OFF_W-1:0]  wr_data;
   } mem_req_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] index;
      logic [SIZE_W-1:0] old;
   } trail_entry_type;

   typedef struct packed {
      logic [TRAIL_AW-1:0] rd_addr;
      logic                wr_en;
      logic [TRAIL_AW-1:0] wr_addr;
      trail_entry_type     wr_data;
   } trail_req_type;

endpackage

>>> rtl/core/rsd_sparse_mem.sv
// Dense offset and position memories, one read and one write port each.
module rsd_sparse_mem (
   input  logic                     clock,
   input  rsd_pkg::mem_req_type     dense_req,
   input  rsd_pkg::mem_req_type     pos_req,
   output logic [rsd_pkg::OFF_W-1:0] dense_rdata,
   output logic [rsd_pkg::OFF_W-1:0] pos_rdata
);
   localparam int DEPTH = rsd_pkg::NUM_VARS * rsd_pkg::MAX_SPAN;

   logic [rsd_pkg::OFF_W-1:0] dense_mem [DEPTH];
   logic [rsd_pkg::OFF_W-1:0] pos_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (dense_req.wr_en) begin
         dense_mem[dense_req.wr_addr] <= dense_req.wr_data;
      end
      if (pos_req.wr_en) begin
         pos_mem[pos_req.wr_addr] <= pos_req.wr_data;
      end
      dense_rdata <= dense_mem[dense_req.rd_addr];
      pos_rdata   <= pos_mem[pos_req.rd_addr];
   end
endmodule

>>> rtl/core/rsd_trail_mem.sv
// Undo trail memory, one read and one write port.
module rsd_trail_mem (
   input  logic                     clock,
   input  rsd_pkg::trail_req_type   trail_req,
   output rsd_pkg::trail_entry_type trail_rdata
);
   rsd_pkg::trail_entry_type trail_mem [rsd_pkg::TRAIL_DEPTH];

   always_ff @(posedge clock) begin
      if (trail_req.wr_en) begin
         trail_mem[trail_req.wr_addr] <= trail_req.wr_data;
      end
      trail_rdata <= trail_mem[trail_req.rd_addr];
   end
endmodule

>>> rtl/core/reversible_sparse_domain_store.sv
// Top level of the reversible sparse domain store: sequencer and small state.
// Sixteen integer domains of up to 64 values, kept as sparse sets in simple dual-port
// dense and position memories, with a 1024-entry undo trail. One transaction is
// worked at a time; a request is taken while the previous response still waits.
// Each transaction passes dispatch, its own steps, then a response step that waits
// while the last response is still stalled. Mark has no steps of its own; read does
// one dense read; contains reads position, then dense; init writes both entries per
// value; remove reads the entries involved and pushes their old values on the trail;
// fix snapshots the dense set and removes every other value; restore pops entries.
`include "assert_macros.svh"

module reversible_sparse_domain_store (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rsd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsd_pkg::rsp_type rsp_data
);
   localparam int OW = rsd_pkg::OFF_W;
   localparam int SW = rsd_pkg::SIZE_W;
   localparam int CW = rsd_pkg::CNT_W;
   localparam int VW = rsd_pkg::VAR_W;

   typedef enum logic [4:0] {
      S_IDLE, S_DISP, S_INIT, S_F_POS, S_F_DENSE, S_F_CHK, S_SNAP_RD, S_SNAP_WR,
      S_FIX_NEXT, S_R_IDX, S_R_LAST, S_R_OLDD, S_R_OLDP, S_R_W0, S_R_W1, S_R_W2,
      S_RD_ISSUE, S_RD, S_RS_READ, S_RS_APPLY, S_DONE
   } state_type;

   state_type state_ff, state_in;
   rsd_pkg::req_type req_ff, req_in;
   logic [OW-1:0] off_ff, off_in, cur_ff, cur_in, idx_ff, idx_in;
   logic [OW-1:0] last_ff, last_in, oldd_ff, oldd_in, oldp_ff, oldp_in;
   logic [SW-1:0] cnt_ff, cnt_in, n_ff, n_in;
   logic [CW-1:0] count_ff, count_in;
   logic present_ff, present_in, failed_ff, failed_in;
   logic [1:0] err_ff, err_in;
   logic [31:0] rd_ff, rd_in;
   logic [SW-1:0] sizes_ff [rsd_pkg::NUM_VARS];
   logic [SW-1:0] sizes_in [rsd_pkg::NUM_VARS];
   logic [SW-1:0] spans_ff [rsd_pkg::NUM_VARS];
   logic [SW-1:0] spans_in [rsd_pkg::NUM_VARS];
   logic [31:0] mins_ff [rsd_pkg::NUM_VARS];
   logic [31:0] mins_in [rsd_pkg::NUM_VARS];
   logic [OW-1:0] snap_ff [rsd_pkg::MAX_SPAN];
   logic [OW-1:0] snap_q_ff;
   logic snap_we;
   logic [OW-1:0] snap_wa, snap_wd;
   rsd_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   rsd_pkg::mem_req_type dense_req, pos_req;
   rsd_pkg::trail_req_type trail_req;
   logic [OW-1:0] dense_rdata, pos_rdata;
   rsd_pkg::trail_entry_type trail_rdata;

   logic [VW-1:0] var_sel;
   logic [SW-1:0] size_cur;
   logic [32:0] diff;
   logic in_range, init_bad, absent_failed;
   logic [12:0] fix_need;

   rsd_sparse_mem u_sparse (
      .clock       (clock),
      .dense_req   (dense_req),
      .pos_req     (pos_req),
      .dense_rdata (dense_rdata),
      .pos_rdata   (pos_rdata)
   );

   rsd_trail_mem u_trail (
      .clock       (clock),
      .trail_req   (trail_req),
      .trail_rdata (trail_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      var_sel  = req_ff.variable;
      size_cur = sizes_ff[var_sel];
      if (req_ff.action == rsd_pkg::ACT_INIT) begin
         diff = {req_ff.value_high[31], req_ff.value_high} - {req_ff.value[31], req_ff.value};
      end else begin
         diff = {req_ff.value[31], req_ff.value} - {mins_ff[var_sel][31], mins_ff[var_sel]};
      end
      in_range = !diff[32] && (diff[31:0] < 32'(spans_ff[var_sel]));
      init_bad = diff[32] || (diff[31:0] >= 32'(rsd_pkg::MAX_SPAN));
      absent_failed = (req_ff.action == rsd_pkg::ACT_FIX) ||
                      ((req_ff.action == rsd_pkg::ACT_REMOVE) && (size_cur == '0));
      fix_need = 13'(count_ff) + 13'(3) * 13'(size_cur - SW'(1));

      state_in = state_ff;
      req_in = req_ff;
      off_in = off_ff;
      cur_in = cur_ff;
      idx_in = idx_ff;
      last_in = last_ff;
      oldd_in = oldd_ff;
      oldp_in = oldp_ff;
      cnt_in = cnt_ff;
      n_in = n_ff;
      count_in = count_ff;
      present_in = present_ff;
      failed_in = failed_ff;
      err_in = err_ff;
      rd_in = rd_ff;
      sizes_in = sizes_ff;
      spans_in = spans_ff;
      mins_in = mins_ff;
      snap_we = 1'b0;
      snap_wa = cnt_ff[OW-1:0];
      snap_wd = dense_rdata;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      dense_req = '0;
      pos_req = '0;
      trail_req = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               present_in = 1'b0;
               failed_in = 1'b0;
               err_in = rsd_pkg::ERR_NONE;
               rd_in = '0;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_DONE;
            unique case (req_ff.action) inside
               rsd_pkg::ACT_INIT: begin
                  if (init_bad) begin
                     err_in = rsd_pkg::ERR_RANGE;
                  end else begin
                     mins_in[var_sel] = req_ff.value;
                     spans_in[var_sel] = SW'(diff[OW-1:0]) + SW'(1);
                     sizes_in[var_sel] = SW'(diff[OW-1:0]) + SW'(1);
                     n_in = SW'(diff[OW-1:0]) + SW'(1);
                     cnt_in = '0;
                     state_in = S_INIT;
                  end
               end
               rsd_pkg::ACT_REMOVE, rsd_pkg::ACT_FIX, rsd_pkg::ACT_CONTAINS: begin
                  if (in_range) begin
                     off_in = diff[OW-1:0];
                     state_in = S_F_POS;
                  end else begin
                     failed_in = absent_failed;
                  end
               end
               rsd_pkg::ACT_READ: begin
                  if (SW'(req_ff.slot) >= size_cur) begin
                     err_in = rsd_pkg::ERR_ARG;
                  end else begin
                     state_in = S_RD_ISSUE;
                  end
               end
               rsd_pkg::ACT_RESTORE: begin
                  if (req_ff.mark > count_ff) begin
                     err_in = rsd_pkg::ERR_ARG;
                  end else begin
                     state_in = S_RS_READ;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_INIT: begin
            dense_req.wr_en = 1'b1;
            dense_req.wr_addr = {var_sel, cnt_ff[OW-1:0]};
            dense_req.wr_data = cnt_ff[OW-1:0];
            pos_req.wr_en = 1'b1;
            pos_req.wr_addr = {var_sel, cnt_ff[OW-1:0]};
            pos_req.wr_data = cnt_ff[OW-1:0];
            cnt_in = cnt_ff + SW'(1);
            if (cnt_ff + SW'(1) == n_ff) begin
               state_in = S_DONE;
            end
         end
         S_F_POS: begin
            pos_req.rd_addr = {var_sel, off_ff};
            state_in = S_F_DENSE;
         end
         S_F_DENSE: begin
            if (SW'(pos_rdata) >= size_cur) begin
               failed_in = absent_failed;
               state_in = S_DONE;
            end else begin
               dense_req.rd_addr = {var_sel, pos_rdata};
               state_in = S_F_CHK;
            end
         end
         S_F_CHK: begin
            state_in = S_DONE;
            if (dense_rdata != off_ff) begin
               failed_in = absent_failed;
            end else begin
               present_in = 1'b1;
               if (req_ff.action == rsd_pkg::ACT_REMOVE) begin
                  if (12'(count_ff) + 12'd3 > 12'(rsd_pkg::TRAIL_DEPTH)) begin
                     err_in = rsd_pkg::ERR_TRAIL;
                  end else begin
                     cur_in = off_ff;
                     state_in = S_R_IDX;
                  end
               end else if (req_ff.action == rsd_pkg::ACT_FIX) begin
                  if (fix_need > 13'(rsd_pkg::TRAIL_DEPTH)) begin
                     err_in = rsd_pkg::ERR_TRAIL;
                  end else begin
                     n_in = size_cur;
                     cnt_in = '0;
                     state_in = S_SNAP_RD;
                  end
               end
            end
         end
         S_SNAP_RD: begin
            dense_req.rd_addr = {var_sel, cnt_ff[OW-1:0]};
            state_in = S_SNAP_WR;
         end
         S_SNAP_WR: begin
            snap_we = 1'b1;
            if (cnt_ff + SW'(1) == n_ff) begin
               cnt_in = '0;
               state_in = S_FIX_NEXT;
            end else begin
               cnt_in = cnt_ff + SW'(1);
               state_in = S_SNAP_RD;
            end
         end
         S_FIX_NEXT: begin
            if (cnt_ff == n_ff) begin
               state_in = S_DONE;
            end else if (snap_q_ff != off_ff) begin
               cur_in = snap_q_ff;
               state_in = S_R_IDX;
            end else begin
               cnt_in = cnt_ff + SW'(1);
            end
         end
         S_R_IDX: begin
            pos_req.rd_addr = {var_sel, cur_ff};
            state_in = S_R_LAST;
         end
         S_R_LAST: begin
            idx_in = pos_rdata;
            dense_req.rd_addr = {var_sel, OW'(size_cur - SW'(1))};
            state_in = S_R_OLDD;
         end
         S_R_OLDD: begin
            last_in = dense_rdata;
            dense_req.rd_addr = {var_sel, idx_ff};
            state_in = S_R_OLDP;
         end
         S_R_OLDP: begin
            oldd_in = dense_rdata;
            pos_req.rd_addr = {var_sel, last_ff};
            state_in = S_R_W0;
         end
         S_R_W0: begin
            oldp_in = pos_rdata;
            trail_req.wr_en = 1'b1;
            trail_req.wr_addr = count_ff[rsd_pkg::TRAIL_AW-1:0];
            trail_req.wr_data = '{rsd_pkg::KIND_DENSE, {var_sel, idx_ff}, SW'(oldd_ff)};
            dense_req.wr_en = 1'b1;
            dense_req.wr_addr = {var_sel, idx_ff};
            dense_req.wr_data = last_ff;
            count_in = count_ff + CW'(1);
            state_in = S_R_W1;
         end
         S_R_W1: begin
            trail_req.wr_en = 1'b1;
            trail_req.wr_addr = count_ff[rsd_pkg::TRAIL_AW-1:0];
            trail_req.wr_data = '{rsd_pkg::KIND_POS, {var_sel, last_ff}, SW'(oldp_ff)};
            pos_req.wr_en = 1'b1;
            pos_req.wr_addr = {var_sel, last_ff};
            pos_req.wr_data = idx_ff;
            count_in = count_ff + CW'(1);
            state_in = S_R_W2;
         end
         S_R_W2: begin
            trail_req.wr_en = 1'b1;
            trail_req.wr_addr = count_ff[rsd_pkg::TRAIL_AW-1:0];
            trail_req.wr_data = '{rsd_pkg::KIND_SIZE, rsd_pkg::ADDR_W'(var_sel), size_cur};
            sizes_in[var_sel] = size_cur - SW'(1);
            count_in = count_ff + CW'(1);
            if (req_ff.action == rsd_pkg::ACT_FIX) begin
               cnt_in = cnt_ff + SW'(1);
               state_in = S_FIX_NEXT;
            end else begin
               failed_in = (size_cur == SW'(1));
               state_in = S_DONE;
            end
         end
         S_RD_ISSUE: begin
            dense_req.rd_addr = {var_sel, req_ff.slot};
            state_in = S_RD;
         end
         S_RD: begin
            rd_in = mins_ff[var_sel] + 32'(dense_rdata);
            state_in = S_DONE;
         end
         S_RS_READ: begin
            if (count_ff == req_ff.mark) begin
               state_in = S_DONE;
            end else begin
               trail_req.rd_addr = rsd_pkg::TRAIL_AW'(count_ff - CW'(1));
               count_in = count_ff - CW'(1);
               state_in = S_RS_APPLY;
            end
         end
         S_RS_APPLY: begin
            case (trail_rdata.kind)
               rsd_pkg::KIND_DENSE: begin
                  dense_req.wr_en = 1'b1;
                  dense_req.wr_addr = trail_rdata.index;
                  dense_req.wr_data = trail_rdata.old[OW-1:0];
               end
               rsd_pkg::KIND_POS: begin
                  pos_req.wr_en = 1'b1;
                  pos_req.wr_addr = trail_rdata.index;
                  pos_req.wr_data = trail_rdata.old[OW-1:0];
               end
               default: begin
                  if (trail_rdata.index[rsd_pkg::ADDR_W-1:VW] == '0) begin
                     sizes_in[trail_rdata.index[VW-1:0]] = trail_rdata.old;
                  end
               end
            endcase
            state_in = S_RS_READ;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.present = present_ff;
               rsp_in.failed = failed_ff;
               rsp_in.domain_size = size_cur;
               rsp_in.read_value = rd_ff;
               rsp_in.trail_length = count_ff;
               rsp_in.error = err_ff;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < rsd_pkg::NUM_VARS; i++) begin
            sizes_ff[i] <= '0;
            spans_ff[i] <= '0;
            mins_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         sizes_ff <= sizes_in;
         spans_ff <= spans_in;
         mins_ff <= mins_in;
      end
      req_ff <= req_in;
      off_ff <= off_in;
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      last_ff <= last_in;
      oldd_ff <= oldd_in;
      oldp_ff <= oldp_in;
      cnt_ff <= cnt_in;
      n_ff <= n_in;
      present_ff <= present_in;
      failed_ff <= failed_in;
      err_ff <= err_in;
      rd_ff <= rd_in;
      rsp_ff <= rsp_in;
      if (snap_we) begin
         snap_ff[snap_wa] <= snap_wd;
      end
      // registered snapshot read at the next walk index, write forwarded
      if (snap_we && (snap_wa == cnt_in[OW-1:0])) begin
         snap_q_ff <= snap_wd;
      end else begin
         snap_q_ff <= snap_ff[cnt_in[OW-1:0]];
      end
   end

   `RSD_ASSERT_IMPL(a_trail_room, clock, reset, trail_req.wr_en, count_ff < CW'(rsd_pkg::TRAIL_DEPTH))
   `RSD_ASSERT_IMPL(a_count_max, clock, reset, 1'b1, count_ff <= CW'(rsd_pkg::TRAIL_DEPTH))
   `RSD_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, state_ff == S_DISP)
   `RSD_ASSERT_NEXT(a_size_push, clock, reset, state_ff == S_R_W2, count_ff == $past(count_ff) + CW'(1))

endmodule

>>> test/reversible_sparse_domain_store_tb.sv
// Testbench of the reversible sparse domain store: directed table, then checked random traffic.
module reversible_sparse_domain_store_tb;

   localparam int RANDOM_ITEMS = 400;
   localparam int STALL_LIMIT  = 20000;
   localparam int MEM_DEPTH    = rsd_pkg::NUM_VARS * rsd_pkg::MAX_SPAN;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   rsd_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsd_pkg::rsp_type rsp_data;

   reversible_sparse_domain_store DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // domain store shadow
   logic [5:0]                 dense_w [MEM_DEPTH];
   logic [5:0]                 pos_w   [MEM_DEPTH];
   logic [6:0]                 dom_size [rsd_pkg::NUM_VARS];
   logic [6:0]                 dom_span [rsd_pkg::NUM_VARS];
   logic [31:0]                dom_min  [rsd_pkg::NUM_VARS];
   logic [1:0]                 undo_kind [rsd_pkg::TRAIL_DEPTH];
   logic [rsd_pkg::ADDR_W-1:0] undo_index [rsd_pkg::TRAIL_DEPTH];
   logic [6:0]                 undo_old [rsd_pkg::TRAIL_DEPTH];
   int                         undo_len;

   rsd_pkg::rsp_type expected_rsps[$];
   int      mismatches;
   int      sent_count;
   bit      quiet;
   int      idle_cycles;

   typedef struct {
      rsd_pkg::req_type req;
      bit               fixed;
      rsd_pkg::rsp_type rsp;
   } row_type;
   row_type rows[$];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic bit lookup(input int v, input longint val, output int off);
      longint d;
      int base;
      d = val - longint'($signed(dom_min[v]));
      base = v * rsd_pkg::MAX_SPAN;
      off = 0;
      if (d < 0 || d >= longint'(dom_span[v])) return 0;
      off = int'(d);
      if (7'(pos_w[base+off]) >= dom_size[v]) return 0;
      if (dense_w[base+int'(pos_w[base+off])] != off[5:0]) return 0;
      return 1;
   endfunction

   function automatic void trail_push(logic [1:0] k, int idx, logic [6:0] old);
      undo_kind[undo_len]  = k;
      undo_index[undo_len] = idx[rsd_pkg::ADDR_W-1:0];
      undo_old[undo_len]   = old;
      undo_len++;
   endfunction

   function automatic void drop_offset(int v, int off);
      int base, idx, last;
      base = v * rsd_pkg::MAX_SPAN;
      idx  = int'(pos_w[base+off]);
      last = int'(dense_w[base+int'(dom_size[v])-1]);
      trail_push(rsd_pkg::KIND_DENSE, base + idx, {1'b0, dense_w[base+idx]});
      trail_push(rsd_pkg::KIND_POS, base + last, {1'b0, pos_w[base+last]});
      trail_push(rsd_pkg::KIND_SIZE, v, dom_size[v]);
      dom_size[v]--;
      dense_w[base+idx] = last[5:0];
      pos_w[base+last]  = idx[5:0];
   endfunction

   function automatic rsd_pkg::rsp_type apply_op(rsd_pkg::req_type r);
      rsd_pkg::rsp_type o;
      int v, off, n, base;
      longint lo, hi, diff;
      logic [5:0] snap[rsd_pkg::MAX_SPAN];
      o = '0;
      v = int'(r.variable);
      base = v * rsd_pkg::MAX_SPAN;
      lo = longint'($signed(r.value));
      hi = longint'($signed(r.value_high));
      case (r.action)
         rsd_pkg::ACT_INIT: begin
            diff = hi - lo;
            if (diff < 0 || diff >= rsd_pkg::MAX_SPAN) o.error = rsd_pkg::ERR_RANGE;
            else begin
               dom_min[v]  = r.value;
               dom_span[v] = 7'(diff + 1);
               dom_size[v] = 7'(diff + 1);
               for (int i = 0; i <= diff; i++) begin
                  dense_w[base+i] = 6'(i);
                  pos_w[base+i]   = 6'(i);
               end
            end
         end
         rsd_pkg::ACT_REMOVE: begin
            if (lookup(v, lo, off)) begin
               o.present = 1;
               if (undo_len + 3 > rsd_pkg::TRAIL_DEPTH) o.error = rsd_pkg::ERR_TRAIL;
               else drop_offset(v, off);
            end
            if (o.error == rsd_pkg::ERR_NONE && dom_size[v] == 0) o.failed = 1;
         end
         rsd_pkg::ACT_FIX: begin
            if (!lookup(v, lo, off)) o.failed = 1;
            else begin
               o.present = 1;
               n = int'(dom_size[v]);
               if (undo_len + 3 * (n - 1) > rsd_pkg::TRAIL_DEPTH) o.error = rsd_pkg::ERR_TRAIL;
               else begin
                  for (int i = 0; i < n; i++) snap[i] = dense_w[base+i];
                  for (int i = 0; i < n; i++)
                     if (snap[i] != off[5:0]) drop_offset(v, int'(snap[i]));
               end
            end
         end
         rsd_pkg::ACT_CONTAINS: o.present = lookup(v, lo, off);
         rsd_pkg::ACT_READ: begin
            if (7'(r.slot) >= dom_size[v]) o.error = rsd_pkg::ERR_ARG;
            else o.read_value = dom_min[v] + 32'(dense_w[base+int'(r.slot)]);
         end
         rsd_pkg::ACT_RESTORE: begin
            if (int'(r.mark) > undo_len) o.error = rsd_pkg::ERR_ARG;
            else while (undo_len > int'(r.mark)) begin
               undo_len--;
               case (undo_kind[undo_len])
                  rsd_pkg::KIND_DENSE:
                     dense_w[undo_index[undo_len]] = undo_old[undo_len][5:0];
                  rsd_pkg::KIND_POS:
                     pos_w[undo_index[undo_len]] = undo_old[undo_len][5:0];
                  default:
                     dom_size[undo_index[undo_len]] = undo_old[undo_len];
               endcase
            end
         end
         default: ;
      endcase
      o.domain_size  = dom_size[v];
      o.trail_length = 11'(undo_len);
      return o;
   endfunction

   function automatic rsd_pkg::req_type make_req(logic [2:0] act, int v, int val, int val_hi,
                                                 int sl, int mk);
      rsd_pkg::req_type r;
      r.action     = act;
      r.variable   = 4'(v);
      r.value      = val;
      r.value_high = val_hi;
      r.slot       = 6'(sl);
      r.mark       = 11'(mk);
      return r;
   endfunction

   function automatic rsd_pkg::rsp_type make_rsp(bit pr, bit fl, int sz, int tl,
                                                 logic [1:0] er);
      rsd_pkg::rsp_type o;
      o = '0;
      o.present = pr;
      o.failed = fl;
      o.domain_size = 7'(sz);
      o.trail_length = 11'(tl);
      o.error = er;
      return o;
   endfunction

   function automatic void add_row(rsd_pkg::req_type r, bit fixed, rsd_pkg::rsp_type o);
      row_type w;
      w.req = r;
      w.fixed = fixed;
      w.rsp = o;
      rows.push_back(w);
   endfunction

   function automatic void build_table();
      int lo;
      lo = 32'h8000_0000;
      add_row(make_req(rsd_pkg::ACT_CONTAINS, 0, 0, 0, 0, 0), 1,
              make_rsp(0, 0, 0, 0, rsd_pkg::ERR_NONE));
      add_row(make_req(rsd_pkg::ACT_READ, 0, 0, 0, 0, 0), 1,
              make_rsp(0, 0, 0, 0, rsd_pkg::ERR_ARG));
      add_row(make_req(rsd_pkg::ACT_MARK, 15, 0, 0, 0, 0), 1,
              make_rsp(0, 0, 0, 0, rsd_pkg::ERR_NONE));
      add_row(make_req(rsd_pkg::ACT_RESTORE, 0, 0, 0, 0, 5), 1,
              make_rsp(0, 0, 0, 0, rsd_pkg::ERR_ARG));
      add_row(make_req(rsd_pkg::ACT_RESTORE, 0, 0, 0, 0, 2047), 1,
              make_rsp(0, 0, 0, 0, rsd_pkg::ERR_ARG));
      add_row(make_req(rsd_pkg::ACT_INIT, 2, 10, 9, 0, 0), 1,
              make_rsp(0, 0, 0, 0, rsd_pkg::ERR_RANGE));
      add_row(make_req(rsd_pkg::ACT_INIT, 2, 0, 64, 0, 0), 1,
              make_rsp(0, 0, 0, 0, rsd_pkg::ERR_RANGE));
      add_row(make_req(rsd_pkg::ACT_INIT, 15, -1, 32'h7fff_ffff, 63, 2047), 1,
              make_rsp(0, 0, 0, 0, rsd_pkg::ERR_RANGE));
      add_row(make_req(rsd_pkg::ACT_INIT, 1, lo, lo + 63, 0, 0), 1,
              make_rsp(0, 0, 64, 0, rsd_pkg::ERR_NONE));
      add_row(make_req(rsd_pkg::ACT_INIT, 3, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0), 1,
              make_rsp(0, 0, 1, 0, rsd_pkg::ERR_NONE));
      add_row(make_req(rsd_pkg::ACT_REMOVE, 3, 32'h7fff_ffff, 0, 0, 0), 0, '0);
      add_row(make_req(rsd_pkg::ACT_REMOVE, 3, 32'h7fff_ffff, 0, 0, 0), 0, '0);
      add_row(make_req(rsd_pkg::ACT_REMOVE, 1, lo, 0, 0, 0), 0, '0);
      add_row(make_req(rsd_pkg::ACT_REMOVE, 1, lo, 0, 0, 0), 0, '0);
      add_row(make_req(rsd_pkg::ACT_CONTAINS, 1, lo + 1, 0, 0, 0), 0, '0);
      add_row(make_req(rsd_pkg::ACT_READ, 1, 0, 0, 63, 0), 0, '0);
      add_row(make_req(rsd_pkg::ACT_READ, 1, 0, 0, 0, 0), 0, '0);
      add_row(make_req(rsd_pkg::ACT_FIX, 1, 100, 0, 0, 0), 0, '0);
      add_row(make_req(rsd_pkg::ACT_MARK, 1, 0, 0, 0, 0), 0, '0);
      add_row(make_req(rsd_pkg::ACT_FIX, 1, lo + 40, 0, 0, 0), 0, '0);
      add_row(make_req(3'd7, 1, -1, -1, 63, 2047), 0, '0);
      add_row(make_req(rsd_pkg::ACT_RESTORE, 1, 0, 0, 0, 6), 0, '0);
      add_row(make_req(rsd_pkg::ACT_READ, 1, 0, 0, 62, 0), 0, '0);
      add_row(make_req(rsd_pkg::ACT_RESTORE, 1, 0, 0, 0, 0), 0, '0);
      add_row(make_req(rsd_pkg::ACT_READ, 1, 0, 0, 62, 0), 0, '0);
   endfunction

   // value near the domain of v, sometimes just outside it
   function automatic int near_value(int v);
      return int'(dom_min[v] + $urandom_range(0, dom_span[v] + 1) - 1);
   endfunction

   function automatic rsd_pkg::req_type random_req(int n);
      rsd_pkg::req_type r;
      logic [95:0] bits;
      int v, k, pick, span, lo;
      bits = {$urandom, $urandom, $urandom};
      r = bits[$bits(rsd_pkg::req_type)-1:0];
      k = n - 200;
      if (k >= 0 && k < 34) begin
         // fill the trail: wide domains fixed, then removals and narrow re-inits, then a restore
         v = 4 + (k % 14) / 2;
         if (k < 14 && k % 2 == 0) begin
            lo = $urandom_range(0, 2000000) - 1000000;
            return make_req(rsd_pkg::ACT_INIT, v, lo, lo + 63, int'(r.slot), int'(r.mark));
         end
         if (k < 14)
            return make_req(rsd_pkg::ACT_FIX, v, near_value(v), r.value_high, int'(r.slot),
                            int'(r.mark));
         if (k < 33) begin
            v = 4 + $urandom_range(0, 6);
            if (k % 4 == 0) begin
               lo = $urandom;
               return make_req(rsd_pkg::ACT_INIT, v, lo, lo + $urandom_range(1, 5),
                               int'(r.slot), 0);
            end
            return make_req(rsd_pkg::ACT_REMOVE, v, near_value(v), r.value_high, int'(r.slot),
                            int'(r.mark));
         end
         return make_req(rsd_pkg::ACT_RESTORE, v, r.value, r.value_high, int'(r.slot), 0);
      end
      pick = $urandom_range(99);
      if (pick < 6) return r;
      v = $urandom_range(0, 3);
      if (pick < 9) v = int'(r.variable);
      r.variable = 4'(v);
      pick = $urandom_range(99);
      if (pick < 12 || dom_span[v] == 0) begin
         span = ($urandom_range(9) == 0) ? 64 : $urandom_range(1, 8);
         if ($urandom_range(9) == 0) span = $urandom_range(1, 70);
         r.action = rsd_pkg::ACT_INIT;
         r.value_high = r.value + span - 1;
      end else if (pick < 40) begin
         r.action = rsd_pkg::ACT_REMOVE;
         r.value = near_value(v);
      end else if (pick < 50) begin
         r.action = rsd_pkg::ACT_FIX;
         r.value = near_value(v);
      end else if (pick < 62) begin
         r.action = rsd_pkg::ACT_CONTAINS;
         r.value = near_value(v);
      end else if (pick < 74) begin
         r.action = rsd_pkg::ACT_READ;
         if ($urandom_range(3) != 0) r.slot = 6'($urandom_range(0, dom_span[v]));
      end else if (pick < 82) begin
         r.action = rsd_pkg::ACT_MARK;
      end else if (pick < 98) begin
         r.action = rsd_pkg::ACT_RESTORE;
         if ($urandom_range(7) != 0) r.mark = 11'($urandom_range(0, undo_len));
      end else begin
         r.action = 3'd7;
      end
      return r;
   endfunction

   task automatic send(rsd_pkg::req_type r);
      int gap;
      if (!quiet && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   initial begin
      rsd_pkg::req_type r;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      mismatches = 0;
      sent_count = 0;
      quiet      = 0;
      undo_len   = 0;
      foreach (dom_size[i]) begin
         dom_size[i] = 0;
         dom_span[i] = 0;
         dom_min[i]  = 0;
      end
      build_table();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) begin
         send(rows[i].req);
         r = rows[i].req;
         if (rows[i].fixed) begin
            void'(apply_op(r));
            expected_rsps.push_back(rows[i].rsp);
         end else expected_rsps.push_back(apply_op(r));
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= 100 && n < 180);
         r = random_req(n);
         send(r);
         expected_rsps.push_back(apply_op(r));
      end
      req_valid <= 1'b0;
      quiet = 0;
      wait (expected_rsps.size() == 0);
      repeat (50) @(posedge clock);
      if (mismatches == 0) $display("reversible_sparse_domain_store test passed");
      else $display("reversible_sparse_domain_store test failed");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !quiet && ($urandom_range(99) < 28);
   end

   always @(posedge clock) begin
      rsd_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction: %p", rsp_data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.present !== want.present || rsp_data.failed !== want.failed ||
                rsp_data.domain_size !== want.domain_size ||
                rsp_data.read_value !== want.read_value ||
                rsp_data.trail_length !== want.trail_length ||
                rsp_data.error !== want.error) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("reversible_sparse_domain_store test failed");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

endmodule

>>> reversible_sparse_domain_store.f
+incdir+rtl/core
rtl/core/rsd_pkg.sv
rtl/core/rsd_sparse_mem.sv
rtl/core/rsd_trail_mem.sv
rtl/core/reversible_sparse_domain_store.sv
test/reversible_sparse_domain_store_tb.sv
